// ===== rtl/med_pkg.sv =====
`default_nettype none

package med_pkg;

    // frame size limits
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    // field and counter widths
    localparam int PIX_W  = 8;
    localparam int DIM_W  = 11;
    localparam int CFG_IW = 2;
    localparam int COL_AW = $clog2(MAX_WIDTH);
    localparam int ROW_AW = $clog2(MAX_HEIGHT);

    // pixel extremes
    localparam logic [PIX_W-1:0] PIX_MIN = 8'd0;
    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    // reset sizes
    localparam logic [DIM_W-1:0] RST_WIDTH  = 11'd640;
    localparam logic [DIM_W-1:0] RST_HEIGHT = 11'd480;

    // request kinds
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // morph modes
    localparam logic MODE_ERODE  = 1'b0;
    localparam logic MODE_DILATE = 1'b1;

    typedef enum logic [CFG_IW-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_MORPH_MODE   = 2'd2
    } t_cfg_idx;

    // effective configuration seen by the datapath
    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] width_m1;
        logic [DIM_W-1:0] height;
        logic [DIM_W-1:0] height_m1;
        logic             mode;
        logic             clear;
    } t_cfg;

    // one request on its way from the counters to the window
    typedef struct packed {
        logic              valid;
        logic              emit;
        logic              left;
        logic              right;
        logic              top;
        logic              bottom;
        logic              last;
        logic [COL_AW-1:0] col;
        logic [PIX_W-1:0]  pixel;
    } t_stage;

endpackage

`default_nettype wire

// ===== rtl/med_if.sv =====
`default_nettype none

interface med_in_if import med_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             operation;
    logic [PIX_W-1:0] pixel_in;

    modport source (output valid, output operation, output pixel_in, input ready);
    modport sink   (input valid, input operation, input pixel_in, output ready);
endinterface

interface med_out_if import med_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_out;
    logic             frame_end;

    modport source (output valid, output pixel_out, output frame_end, input ready);
    modport sink   (input valid, input pixel_out, input frame_end, output ready);
endinterface

interface med_cfg_if import med_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CFG_IW-1:0] index;
    logic [DIM_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/morph_erode_dilate_3x3.sv =====
// a result passes the stage register, then the output register, after the request whose pixel completes its window
// throughput: one request per cycle, held back only while the output register waits
// the line memories are read as a request is taken, into read registers that feed the window beside the stage
// reset: synchronous, active low; counters, window, output valid and sizes return to default
// line memories are not cleared, stale entries read in a frame are only used where the edge clamp masks them
`default_nettype none

module morph_erode_dilate_3x3 import med_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    med_in_if.sink     i_in,
    med_out_if.source  o_out,
    med_cfg_if.sink    i_cfg
);

    t_cfg              cfg;
    t_stage            stage;
    logic              advance, accept, take;
    logic [COL_AW-1:0] col;
    logic [PIX_W-1:0]  up1, up2;
    logic              out_valid;

    // whole pipe moves whenever the output register is free or being emptied
    assign advance     = !out_valid || o_out.ready;
    assign accept      = i_in.valid && advance;
    assign i_in.ready  = advance;

    // writes are to land only while idle, which the block does not enforce; they are always taken
    assign i_cfg.ready = 1'b1;

    med_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cfg.valid),
        .i_index (i_cfg.index),
        .i_data  (i_cfg.data),
        .o_cfg   (cfg)
    );

    // raster position, drain tracking, centre coordinates
    med_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_advance (advance),
        .i_op      (i_in.operation),
        .i_pixel   (i_in.pixel_in),
        .i_cfg     (cfg),
        .o_take    (take),
        .o_col     (col),
        .o_stage   (stage)
    );

    // two rows of history, addressed by column
    med_line_buf u_line_buf (
        .i_clk    (i_clk),
        .i_take   (take),
        .i_col    (col),
        .i_pixel  (i_in.pixel_in),
        .i_fire   (advance && stage.valid),
        .i_wr_col (stage.col),
        .o_up1    (up1),
        .o_up2    (up2)
    );

    // 3x3 neighbourhood test and output register
    med_window u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_stage     (stage),
        .i_up1       (up1),
        .i_up2       (up2),
        .i_mode      (cfg.mode),
        .o_valid     (out_valid),
        .o_pixel     (o_out.pixel_out),
        .o_frame_end (o_out.frame_end)
    );

    assign o_out.valid = out_valid;

endmodule

`default_nettype wire

// ===== rtl/med_cfg.sv =====
`default_nettype none

module med_cfg import med_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [CFG_IW-1:0] i_index,
    input  wire logic [DIM_W-1:0]  i_data,
    output t_cfg                   o_cfg
);

    logic [DIM_W-1:0] r_width, r_width_m1, r_height, r_height_m1;
    logic             r_mode;
    logic [DIM_W-1:0] n_width, n_height;
    logic             size_wr;

    // saturate to 1..max
    always_comb begin
        if (i_data == '0) begin
            n_width  = DIM_W'(1);
            n_height = DIM_W'(1);
        end else begin
            n_width  = (i_data > DIM_W'(MAX_WIDTH))  ? DIM_W'(MAX_WIDTH)  : i_data;
            n_height = (i_data > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : i_data;
        end
    end

    assign size_wr = i_valid && ((i_index == CFG_FRAME_WIDTH) || (i_index == CFG_FRAME_HEIGHT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= RST_WIDTH;
            r_width_m1  <= RST_WIDTH - DIM_W'(1);
            r_height    <= RST_HEIGHT;
            r_height_m1 <= RST_HEIGHT - DIM_W'(1);
            r_mode      <= MODE_ERODE;
        end else if (i_valid) begin
            unique case (i_index)
                CFG_FRAME_WIDTH: begin
                    r_width    <= n_width;
                    r_width_m1 <= n_width - DIM_W'(1);
                end
                CFG_FRAME_HEIGHT: begin
                    r_height    <= n_height;
                    r_height_m1 <= n_height - DIM_W'(1);
                end
                CFG_MORPH_MODE: begin
                    r_mode <= i_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_cfg.width     = r_width;
        o_cfg.width_m1  = r_width_m1;
        o_cfg.height    = r_height;
        o_cfg.height_m1 = r_height_m1;
        o_cfg.mode      = r_mode;
        o_cfg.clear     = size_wr;
    end

endmodule

`default_nettype wire

// ===== rtl/med_ctrl.sv =====
`default_nettype none

module med_ctrl import med_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire logic             i_advance,
    input  wire logic             i_op,
    input  wire logic [PIX_W-1:0] i_pixel,
    input  wire t_cfg             i_cfg,
    output logic                  o_take,
    output logic [COL_AW-1:0]     o_col,
    output t_stage                o_stage
);

    logic [COL_AW-1:0] r_col, n_col;
    logic [DIM_W-1:0]  r_row, n_row;
    logic [DIM_W-1:0]  r_drain, n_drain;
    logic [COL_AW-1:0] r_cen_col, n_cen_col;
    logic [ROW_AW-1:0] r_cen_row, n_cen_row;
    t_stage            r_stage, n_stage;

    logic              frame_done, is_pixel, drain_ok, restart, take;
    logic [DIM_W-1:0]  cur_row;
    logic [COL_AW-1:0] cur_col;
    logic              col_last, drain_last, emit;
    logic              cen_left, cen_right, cen_top, cen_bottom;

    assign frame_done = r_row >= i_cfg.height;
    assign is_pixel   = i_op == OP_PIXEL;
    assign drain_ok   = (i_op == OP_DRAIN) && frame_done && (r_drain <= i_cfg.width);
    assign restart    = is_pixel && frame_done;
    assign take       = i_accept && (is_pixel || drain_ok);

    assign cur_row    = restart ? '0 : r_row;
    assign cur_col    = restart ? '0 : r_col;
    assign col_last   = DIM_W'(cur_col) == i_cfg.width_m1;
    assign drain_last = r_drain == i_cfg.width;

    // a result is due once the pixel below-right of the centre is in
    always_comb begin
        if (is_pixel) begin
            emit = (cur_row >= DIM_W'(2)) || ((cur_row == DIM_W'(1)) && (cur_col != '0));
        end else begin
            emit = (i_cfg.height != DIM_W'(1)) || (r_drain != '0);
        end
    end

    assign cen_left   = r_cen_col == '0;
    assign cen_right  = DIM_W'(r_cen_col) == i_cfg.width_m1;
    assign cen_top    = r_cen_row == '0;
    assign cen_bottom = DIM_W'(r_cen_row) == i_cfg.height_m1;

    always_comb begin
        n_col     = r_col;
        n_row     = r_row;
        n_drain   = r_drain;
        n_cen_col = r_cen_col;
        n_cen_row = r_cen_row;
        if (i_cfg.clear) begin
            n_col     = '0;
            n_row     = '0;
            n_drain   = '0;
            n_cen_col = '0;
            n_cen_row = '0;
        end else if (take) begin
            if (is_pixel) begin
                n_drain = '0;
                if (col_last) begin
                    n_col = '0;
                    n_row = cur_row + DIM_W'(1);
                end else begin
                    n_col = cur_col + COL_AW'(1);
                    n_row = cur_row;
                end
            end else begin
                n_drain = r_drain + DIM_W'(1);
                n_col   = col_last ? '0 : r_col + COL_AW'(1);
            end
            // centre position of the next result
            if (restart) begin
                n_cen_col = '0;
                n_cen_row = '0;
            end else if (emit) begin
                if (cen_right && cen_bottom) begin
                    n_cen_col = '0;
                    n_cen_row = '0;
                end else if (cen_right) begin
                    n_cen_col = '0;
                    n_cen_row = r_cen_row + ROW_AW'(1);
                end else begin
                    n_cen_col = r_cen_col + COL_AW'(1);
                end
            end
            // tail flushed
            if (!is_pixel && drain_last) begin
                n_col     = '0;
                n_row     = '0;
                n_drain   = '0;
                n_cen_col = '0;
                n_cen_row = '0;
            end
        end
    end

    always_comb begin
        n_stage.valid  = take;
        n_stage.emit   = emit && !restart;
        n_stage.left   = cen_left;
        n_stage.right  = cen_right;
        n_stage.top    = cen_top;
        n_stage.bottom = cen_bottom;
        n_stage.last   = cen_right && cen_bottom;
        n_stage.col    = cur_col;
        n_stage.pixel  = i_pixel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_drain   <= '0;
            r_cen_col <= '0;
            r_cen_row <= '0;
            r_stage   <= '0;
        end else begin
            r_col     <= n_col;
            r_row     <= n_row;
            r_drain   <= n_drain;
            r_cen_col <= n_cen_col;
            r_cen_row <= n_cen_row;
            if (i_advance) begin
                r_stage <= n_stage;
            end
        end
    end

    assign o_take  = take;
    assign o_col   = cur_col;
    assign o_stage = r_stage;

endmodule

`default_nettype wire

// ===== rtl/med_line_buf.sv =====
`default_nettype none

module med_line_buf import med_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_take,
    input  wire logic [COL_AW-1:0] i_col,
    input  wire logic [PIX_W-1:0]  i_pixel,
    input  wire logic              i_fire,
    input  wire logic [COL_AW-1:0] i_wr_col,
    output logic [PIX_W-1:0]       o_up1,
    output logic [PIX_W-1:0]       o_up2
);

    logic [PIX_W-1:0] r_line1 [MAX_WIDTH];
    logic [PIX_W-1:0] r_line2 [MAX_WIDTH];
    logic [PIX_W-1:0] r_rd1, r_rd2;
    logic             fwd;

    // row above, read before write
    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_rd1          <= r_line1[i_col];
            r_line1[i_col] <= i_pixel;
        end
    end

    // line 2 is written back at the previous request's column, forwarded on a clash
    assign fwd = i_fire && (i_wr_col == i_col);

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_rd2 <= fwd ? r_rd1 : r_line2[i_col];
        end
        if (i_fire) begin
            r_line2[i_wr_col] <= r_rd1;
        end
    end

    assign o_up1 = r_rd1;
    assign o_up2 = r_rd2;

endmodule

`default_nettype wire

// ===== rtl/med_window.sv =====
`default_nettype none

module med_window import med_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_advance,
    input  wire t_stage           i_stage,
    input  wire logic [PIX_W-1:0] i_up1,
    input  wire logic [PIX_W-1:0] i_up2,
    input  wire logic             i_mode,
    output logic                  o_valid,
    output logic [PIX_W-1:0]      o_pixel,
    output logic                  o_frame_end
);

    // element 0 is the top row, 2 the bottom
    typedef logic [2:0][PIX_W-1:0] t_col;

    t_col             r_left, r_mid, new_col, lcol, rcol;
    logic             r_valid, r_frame_end;
    logic [PIX_W-1:0] r_pixel, target, result;
    logic             fire, hit;

    function automatic logic col_hit(input t_col c, input logic top, input logic bot,
                                     input logic with_mid, input logic [PIX_W-1:0] tgt);
        logic [PIX_W-1:0] up, dn;
        up = top ? c[1] : c[0];
        dn = bot ? c[1] : c[2];
        return (up == tgt) || (dn == tgt) || (with_mid && (c[1] == tgt));
    endfunction

    assign fire    = i_advance && i_stage.valid;
    assign new_col = {i_stage.pixel, i_up1, i_up2};
    assign target  = (i_mode == MODE_DILATE) ? PIX_MAX : PIX_MIN;

    // clamp at the frame edges
    assign lcol = i_stage.left  ? r_mid : r_left;
    assign rcol = i_stage.right ? r_mid : new_col;

    assign hit = col_hit(lcol,  i_stage.top, i_stage.bottom, 1'b1, target)
              || col_hit(r_mid, i_stage.top, i_stage.bottom, 1'b0, target)
              || col_hit(rcol,  i_stage.top, i_stage.bottom, 1'b1, target);

    assign result = hit ? target : r_mid[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left  <= '0;
            r_mid   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_left <= r_mid;
                r_mid  <= new_col;
            end
            if (i_advance) begin
                r_valid <= fire && i_stage.emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && i_stage.emit) begin
            r_pixel     <= result;
            r_frame_end <= i_stage.last;
        end
    end

    assign o_valid     = r_valid;
    assign o_pixel     = r_pixel;
    assign o_frame_end = r_frame_end;

endmodule

`default_nettype wire

// ===== rtl/med_checker.sv =====
`default_nettype none

module med_checker import med_pkg::*; (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_in_valid,
    input wire logic             i_in_ready,
    input wire logic             i_out_valid,
    input wire logic             i_out_ready,
    input wire logic [PIX_W-1:0] i_pixel_out,
    input wire logic             i_frame_end
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_pixel_out) && $stable(i_frame_end)))
        else $error("result changed while stalled");

    // requests are refused only while a result waits
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> (i_out_valid && !i_out_ready))
        else $error("request refused with free output register");

    // a cycle with no request leaves a gap at the output once the pipe moves on
    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_ready && !i_in_valid) ##1 i_in_ready |=> !i_out_valid)
        else $error("result without a request");

endmodule

bind morph_erode_dilate_3x3 med_checker u_med_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_pixel_out (o_out.pixel_out),
    .i_frame_end (o_out.frame_end)
);

`default_nettype wire

// ===== dv/morph_erode_dilate_3x3_checker.sv =====
module morph_erode_dilate_3x3_checker import med_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    med_in_if    i_pix,
    med_out_if   i_res,
    med_cfg_if   i_cfg,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_DEPTH = 2 * MAX_WIDTH + 4;
    localparam int SHOW_LIMIT = 10;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             last;
    } t_morph_result;

    logic [PIX_W-1:0] recent_pixels [RING_DEPTH];
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic             mode_reg;
    int               col_cnt;
    int               row_cnt;
    int               flush_cnt;
    int               fail_cnt;
    t_morph_result    expected_pixels [$];

    function automatic int clamp_dim(input logic [DIM_W-1:0] raw, input int limit);
        if (raw < 1) return 1;
        if (int'(raw) > limit) return limit;
        return int'(raw);
    endfunction

    function automatic logic [PIX_W-1:0] stored_pixel(input int w, input int r, input int c);
        return recent_pixels[(r * w + c) % RING_DEPTH];
    endfunction

    function automatic void restart_frame();
        col_cnt   = 0;
        row_cnt   = 0;
        flush_cnt = 0;
    endfunction

    // centre kept unless a neighbour, clamped to the frame, sits at the target level
    function automatic t_morph_result morph_at(input int w, input int h, input int k);
        t_morph_result    res;
        logic [PIX_W-1:0] target;
        logic             hit;
        int               r;
        int               c;
        int               rr;
        int               cc;
        r      = k / w;
        c      = k % w;
        target = (mode_reg == MODE_DILATE) ? PIX_MAX : PIX_MIN;
        hit    = 1'b0;
        for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
                if (dr == 0 && dc == 0) continue;
                rr = r + dr;
                cc = c + dc;
                if (rr < 0) rr = 0;
                if (rr > h - 1) rr = h - 1;
                if (cc < 0) cc = 0;
                if (cc > w - 1) cc = w - 1;
                if (stored_pixel(w, rr, cc) == target) hit = 1'b1;
            end
        end
        res.pixel = hit ? target : stored_pixel(w, r, c);
        res.last  = (k == w * h - 1);
        return res;
    endfunction

    function automatic void advance_stream(input logic op, input logic [PIX_W-1:0] pix);
        int w;
        int h;
        int n;
        int t;
        w = clamp_dim(width_reg, MAX_WIDTH);
        h = clamp_dim(height_reg, MAX_HEIGHT);
        if (op == OP_PIXEL) begin
            if (row_cnt >= h) restart_frame();
            n = row_cnt * w + col_cnt;
            recent_pixels[n % RING_DEPTH] = pix;
            col_cnt++;
            if (col_cnt >= w) begin
                col_cnt = 0;
                row_cnt++;
            end
            if (n >= w + 1) expected_pixels.push_back(morph_at(w, h, n - w - 1));
        end else if (row_cnt >= h && flush_cnt < w + 1) begin
            t = w * h + flush_cnt;
            flush_cnt++;
            if (t >= w + 1) expected_pixels.push_back(morph_at(w, h, t - w - 1));
            if (flush_cnt >= w + 1) restart_frame();
        end
    endfunction

    always @(posedge i_clk) begin
        t_morph_result want;
        if (!i_rst_n) begin
            width_reg  = RST_WIDTH;
            height_reg = RST_HEIGHT;
            mode_reg   = MODE_ERODE;
            foreach (recent_pixels[i]) recent_pixels[i] = '0;
            restart_frame();
            expected_pixels.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_FRAME_WIDTH: begin
                        width_reg = i_cfg.data;
                        restart_frame();
                    end
                    CFG_FRAME_HEIGHT: begin
                        height_reg = i_cfg.data;
                        restart_frame();
                    end
                    CFG_MORPH_MODE: mode_reg = i_cfg.data[0];
                    default: ;
                endcase
            end
            if (i_pix.valid && i_pix.ready) advance_stream(i_pix.operation, i_pix.pixel_in);
            if (i_res.valid && i_res.ready) begin
                if (expected_pixels.size() == 0) begin
                    if (fail_cnt < SHOW_LIMIT)
                        $display("%0t: result with none expected: pixel %0d end %0b",
                                 $time, i_res.pixel_out, i_res.frame_end);
                    fail_cnt++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (want.pixel !== i_res.pixel_out || want.last !== i_res.frame_end) begin
                        if (fail_cnt < SHOW_LIMIT)
                            $display("%0t: expected pixel %0d end %0b, got pixel %0d end %0b",
                                     $time, want.pixel, want.last,
                                     i_res.pixel_out, i_res.frame_end);
                        fail_cnt++;
                    end
                end
            end
        end
        o_pending    <= expected_pixels.size();
        o_fail_count <= fail_cnt;
    end

    initial begin
        fail_cnt     = 0;
        o_pending    = 0;
        o_fail_count = 0;
    end

endmodule

// ===== dv/morph_erode_dilate_3x3_tb.sv =====
module morph_erode_dilate_3x3_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import med_pkg::*;

    // run control
    localparam int SETTLE_CYCLES = 8;      // covers the two-stage window pipeline
    localparam int TAIL_CYCLES   = 16;
    localparam int TIMEOUT_NS    = 3_000_000;
    localparam int PHASE_ITEMS   = 220;
    localparam int EXTREME_PIX   = 24;

    // register index with no register behind it
    localparam logic [CFG_IW-1:0] CFG_SPARE = CFG_IW'(3);

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;

    // idling percentages for the two sides
    int   src_idle_pct;
    int   sink_idle_pct;
    int   items_sent;

    // effective frame size as the block sees it
    int   frame_w;
    int   frame_h;

    med_in_if  pix_ch ();
    med_out_if res_ch ();
    med_cfg_if cfg_ch ();

    morph_erode_dilate_3x3 u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (pix_ch),
        .o_out   (res_ch),
        .i_cfg   (cfg_ch)
    );

    morph_erode_dilate_3x3_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pix        (pix_ch),
        .i_res        (res_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // hard stop in case the pipeline hangs
    initial begin
        #(TIMEOUT_NS);
        $display("** morph_erode_dilate_3x3: FAILED **");
        $finish;
    end

    // receiver side, ready drawn afresh every cycle
    initial begin
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            res_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    // pixels weighted towards the two levels that erode and dilate look for
    function automatic logic [PIX_W-1:0] rand_pixel();
        case ($urandom_range(0, 3))
            0:       return PIX_MIN;
            1:       return PIX_MAX;
            default: return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic int clamp_dim(input int raw, input int limit);
        if (raw < 1) return 1;
        if (raw > limit) return limit;
        return raw;
    endfunction

    // one pixel or drain request; valid stays high for a following request
    task automatic push_request(input logic op, input logic [PIX_W-1:0] pix, input bit counted);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            pix_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_ch.valid     <= 1'b1;
        pix_ch.operation <= op;
        pix_ch.pixel_in  <= pix;
        do @(posedge i_clk); while (!pix_ch.ready);
        if (counted) items_sent++;
    endtask

    // hold the sender back until every predicted result has been taken
    task automatic wait_results_done();
        pix_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // idle point for register writes: results out, then let the pipeline empty
    task automatic settle_block();
        wait_results_done();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // register write; valid left high so writes can follow back to back
    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [DIM_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
    endtask

    task automatic write_size(input int raw_w, input int raw_h);
        write_reg(CFG_FRAME_WIDTH, DIM_W'(raw_w));
        write_reg(CFG_FRAME_HEIGHT, DIM_W'(raw_h));
        frame_w = clamp_dim(raw_w, MAX_WIDTH);
        frame_h = clamp_dim(raw_h, MAX_HEIGHT);
    endtask

    // upper data bits are don't-care for the mode register, so randomise them
    task automatic write_mode(input logic mode);
        logic [DIM_W-1:0] data;
        data    = DIM_W'($urandom_range(0, (1 << DIM_W) - 1));
        data[0] = mode;
        write_reg(CFG_MORPH_MODE, data);
    endtask

    // pixels with the odd stray drain mixed in, then drain requests;
    // hold_at names the pixel before which the sender waits for the pipeline
    task automatic play_frame(input int npix, input int ndrain, input int hold_at);
        for (int i = 0; i < npix; i++) begin
            if (i == hold_at) wait_results_done();
            if (i > 0 && $urandom_range(0, 99) < 3) push_request(OP_DRAIN, rand_pixel(), 1'b0);
            push_request(OP_PIXEL, rand_pixel(), 1'b1);
        end
        for (int i = 0; i < ndrain; i++) push_request(OP_DRAIN, rand_pixel(), 1'b1);
    endtask

    // start of a frame at a given raw size, broken off early, used for the size extremes
    task automatic big_frame(input int raw_w, input int raw_h, input int npix);
        settle_block();
        write_size(raw_w, raw_h);
        write_mode(logic'($urandom_range(0, 1)));
        cfg_ch.valid <= 1'b0;
        play_frame(npix, 2, -1);
    endtask

    // random frames, mostly well formed, some cut short or over-drained
    task automatic run_phase(input int src_pct, input int sink_pct, input int quota);
        int stop_at;
        int npix;
        int ndrain;
        int hold_at;
        int pick;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        stop_at       = items_sent + quota;
        while (items_sent < stop_at) begin
            settle_block();
            // width: zero saturates to one, mostly narrow, now and then wider
            pick = $urandom_range(0, 19);
            if (pick == 0) npix = 0;
            else if (pick < 15) npix = $urandom_range(1, 8);
            else npix = $urandom_range(9, 40);
            ndrain = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
            write_size(npix, ndrain);
            write_mode(logic'($urandom_range(0, 1)));
            if ($urandom_range(0, 4) == 0)
                write_reg(CFG_SPARE, DIM_W'($urandom_range(0, (1 << DIM_W) - 1)));
            cfg_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) begin
                npix   = frame_w * frame_h;
                ndrain = frame_w + 1;
                case ($urandom_range(0, 9))
                    // drain cut short: the next frame starts over the tail
                    7: ndrain = $urandom_range(0, frame_w);
                    // frame broken off, drains arrive too early
                    8: begin
                        npix   = $urandom_range(0, npix - 1);
                        ndrain = $urandom_range(0, 2);
                    end
                    // surplus drains after the tail is flushed
                    9: ndrain = frame_w + 1 + $urandom_range(1, 3);
                    default: ;
                endcase
                hold_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, npix) : -1;
                // mode change mid-stream, frame counters untouched
                if ($urandom_range(0, 3) == 0) begin
                    settle_block();
                    write_mode(logic'($urandom_range(0, 1)));
                    cfg_ch.valid <= 1'b0;
                end
                play_frame(npix, ndrain, hold_at);
            end
        end
    endtask

    initial begin
        logic [PIX_W-1:0] edge_px [9];
        edge_px = '{PIX_MAX, PIX_MIN, PIX_MAX, 8'd128, 8'd1, 8'd254, PIX_MAX, PIX_MAX, PIX_MAX};

        src_idle_pct  = 37;
        sink_idle_pct = 72;
        items_sent    = 0;
        frame_w       = RST_WIDTH;
        frame_h       = RST_HEIGHT;

        i_rst_n          <= 1'b0;
        pix_ch.valid     <= 1'b0;
        pix_ch.operation <= OP_PIXEL;
        pix_ch.pixel_in  <= '0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= CFG_FRAME_WIDTH;
        cfg_ch.data      <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // 3x3 erode frame, all-zero mode data, write to the spare index ignored
        write_size(3, 3);
        write_reg(CFG_MORPH_MODE, {{(DIM_W - 1){1'b0}}, MODE_ERODE});
        write_reg(CFG_SPARE, '1);
        cfg_ch.valid <= 1'b0;
        // drain with no frame pending does nothing
        push_request(OP_DRAIN, PIX_MAX, 1'b1);
        foreach (edge_px[i]) push_request(OP_PIXEL, edge_px[i], 1'b1);
        repeat (4) push_request(OP_DRAIN, PIX_MIN, 1'b1);

        // width zero saturates to one, single row: first drain gives nothing
        settle_block();
        write_size(0, 1);
        write_reg(CFG_MORPH_MODE, {{(DIM_W - 1){1'b1}}, MODE_DILATE});
        cfg_ch.valid <= 1'b0;
        push_request(OP_PIXEL, PIX_MAX, 1'b1);
        repeat (2) push_request(OP_DRAIN, PIX_MIN, 1'b1);

        // 2x2 dilate with an early drain in the middle of the frame
        settle_block();
        write_size(2, 2);
        cfg_ch.valid <= 1'b0;
        push_request(OP_PIXEL, PIX_MIN, 1'b1);
        push_request(OP_PIXEL, PIX_MAX, 1'b1);
        push_request(OP_DRAIN, PIX_MAX, 1'b1);
        push_request(OP_PIXEL, 8'h7F, 1'b1);
        push_request(OP_PIXEL, 8'h80, 1'b1);
        repeat (3) push_request(OP_DRAIN, 8'h55, 1'b1);

        // random traffic under two idling patterns
        run_phase(37, 72, PHASE_ITEMS);
        run_phase(72, 37, PHASE_ITEMS);

        // size saturation at both ends at full rate, frames broken off early, then random traffic at full rate
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        big_frame((1 << DIM_W) - 1, 0, EXTREME_PIX);
        big_frame(0, (1 << DIM_W) - 1, EXTREME_PIX);
        run_phase(0, 0, PHASE_ITEMS);

        wait_results_done();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("** morph_erode_dilate_3x3: PASSED **");
        else
            $display("** morph_erode_dilate_3x3: FAILED **");
        $finish;
    end

endmodule
